>>> src/rfp_pkg.sv
// Package with the shared types, constants and reduction-table function of the fingerprint hash.
`timescale 1ns / 1ps

package rfp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [63:0] RABIN_POLY = 64'd9271613880639673933;

    localparam int unsigned SHIFT_A = 88;
    localparam int unsigned SHIFT_B = 80;
    localparam int unsigned SHIFT_C = 72;
    localparam int unsigned SHIFT_D = 64;

    typedef logic [1:0] op_t;

    localparam op_t OP_LOAD_HIGH = 2'd0;
    localparam op_t OP_LOAD_LOW  = 2'd1;
    localparam op_t OP_FOLD      = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
        logic        last;
    } cmd_t;

    // Byte times x^shift reduced modulo the polynomial, reducing whenever bit 63 is set.
    function automatic logic [63:0] rom_entry(input logic [7:0] value, input int unsigned shift);
        logic [63:0] n;
        n = {56'd0, value};
        for (int unsigned k = 0; k < SHIFT_A; k++)
        begin
            if (k < shift)
            begin
                if (n[63])
                begin
                    n = n ^ RABIN_POLY;
                end
                n = {n[62:0], 1'b0};
            end
        end
        if (n[63])
        begin
            n = n ^ RABIN_POLY;
        end
        return n;
    endfunction

endpackage

>>> src/rfp_if.sv
// Valid/ready channel interfaces for message words and fingerprints.
`timescale 1ns / 1ps

interface rfp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        first_word;
    logic        last_word;

    modport source (output valid, output data_word, output first_word, output last_word,
                    input ready);
    modport sink (input valid, input data_word, input first_word, input last_word,
                  output ready);
endinterface

interface rfp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] fingerprint;

    modport source (output valid, output fingerprint, input ready);
    modport sink (input valid, input fingerprint, output ready);
endinterface

>>> src/rfp_front.sv
// Front end: accepts message words and classifies each as a high load, low load or fold.
`timescale 1ns / 1ps

module rfp_front (
    input  logic            clk,
    input  logic            rst_n,
    rfp_in_if.sink          req,
    output logic            push_valid,
    input  logic            push_ready,
    output rfp_pkg::cmd_t   push_cmd
);

    localparam logic [1:0] WS_NONE = 2'd0;
    localparam logic [1:0] WS_ONE  = 2'd1;
    localparam logic [1:0] WS_MANY = 2'd2;

    logic [1:0]     ws_reg;
    logic [1:0]     ws_next;
    rfp_pkg::op_t   op;
    logic           accept;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;
    assign accept     = req.valid && push_ready;

    always_comb
    begin
        if (req.first_word || ws_reg == WS_NONE)
        begin
            op      = rfp_pkg::OP_LOAD_HIGH;
            ws_next = WS_ONE;
        end
        else if (ws_reg == WS_ONE)
        begin
            op      = rfp_pkg::OP_LOAD_LOW;
            ws_next = WS_MANY;
        end
        else
        begin
            op      = rfp_pkg::OP_FOLD;
            ws_next = WS_MANY;
        end
        if (req.last_word)
        begin
            ws_next = WS_NONE;
        end
    end

    assign push_cmd = '{op: op, word: req.data_word, last: req.last_word};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_NONE;
        end
        else if (accept)
        begin
            ws_reg <= ws_next;
        end
    end

endmodule

>>> src/rfp_queue.sv
// Short command queue between the front end and the fold engine.
`timescale 1ns / 1ps

module rfp_queue #(
    parameter int unsigned DEPTH = rfp_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rfp_pkg::cmd_t   push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rfp_pkg::cmd_t   pop_cmd
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rfp_pkg::cmd_t      entry_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> src/rfp_back.sv
// Fold engine: holds the 64-bit state, folds words through the reduction tables, registers results.
`timescale 1ns / 1ps

module rfp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  rfp_pkg::cmd_t   pop_cmd,
    rfp_out_if.source       rsp
);

    logic [63:0] tab_a [256];
    logic [63:0] tab_b [256];
    logic [63:0] tab_c [256];
    logic [63:0] tab_d [256];

    for (genvar i = 0; i < 256; i++)
    begin : g_rom
        localparam logic [63:0] ENTRY_A = rfp_pkg::rom_entry(8'(i), rfp_pkg::SHIFT_A);
        localparam logic [63:0] ENTRY_B = rfp_pkg::rom_entry(8'(i), rfp_pkg::SHIFT_B);
        localparam logic [63:0] ENTRY_C = rfp_pkg::rom_entry(8'(i), rfp_pkg::SHIFT_C);
        localparam logic [63:0] ENTRY_D = rfp_pkg::rom_entry(8'(i), rfp_pkg::SHIFT_D);
        assign tab_a[i] = ENTRY_A;
        assign tab_b[i] = ENTRY_B;
        assign tab_c[i] = ENTRY_C;
        assign tab_d[i] = ENTRY_D;
    end

    logic [31:0] high_reg;
    logic [31:0] high_next;
    logic [31:0] low_reg;
    logic [31:0] low_next;
    logic        out_valid_reg;
    logic [63:0] fp_reg;
    logic [63:0] mix;
    logic [63:0] folded;
    logic        pop;

    assign pop_ready = !out_valid_reg || rsp.ready;
    assign pop       = pop_valid && pop_ready;

    assign mix = tab_a[high_reg[31:24]] ^ tab_b[high_reg[23:16]]
               ^ tab_c[high_reg[15:8]] ^ tab_d[high_reg[7:0]];
    assign folded = {low_reg, pop_cmd.word} ^ mix;

    always_comb
    begin
        case (pop_cmd.op)
            rfp_pkg::OP_LOAD_HIGH:
            begin
                high_next = pop_cmd.word;
                low_next  = '0;
            end
            rfp_pkg::OP_LOAD_LOW:
            begin
                high_next = high_reg;
                low_next  = pop_cmd.word;
            end
            default:
            begin
                high_next = folded[63:32];
                low_next  = folded[31:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg      <= '0;
            low_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                high_reg <= high_next;
                low_reg  <= low_next;
            end
            if (pop && pop_cmd.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_cmd.last)
        begin
            fp_reg <= {high_next, low_next};
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.fingerprint = fp_reg;

endmodule

>>> src/rabin_fingerprint_word_hash.sv
// Top level of the word-serial 64-bit Rabin fingerprint hash.
// The block takes one 32-bit message word per cycle while the queue has room. On a word marked
// last it delivers the 64-bit fingerprint in the cycle after that word leaves the command queue.
// With the output free, a word is accepted every cycle, and a result is offered once its last
// word has passed the queue and the output register. The rate is set by the fold engine, which
// reads four constant 256-entry reduction tables and XORs them into the state for each word.
// The front end classifies words into a short queue, so input transfers continue until that
// queue is full while a finished fingerprint waits at the output register.
`timescale 1ns / 1ps

module rabin_fingerprint_word_hash #(
    parameter int unsigned QUEUE_DEPTH = rfp_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    rfp_in_if.sink      req,
    rfp_out_if.source   rsp
);

    logic           push_valid;
    logic           push_ready;
    rfp_pkg::cmd_t  push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    rfp_pkg::cmd_t  pop_cmd;

    rfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    rfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    rfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );

endmodule

>>> src/rfp_checker.sv
// Port-level assertions for the fingerprint hash and the bind that attaches them.
`timescale 1ns / 1ps

module rfp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] fingerprint
);

    // A pending result stays offered until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("fingerprint withdrawn before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fingerprint))
        else $error("fingerprint changed while stalled");

    // With the output free the fold engine drains the queue, so input stays open.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!out_valid || out_ready) |-> in_ready)
        else $error("input blocked although the output was free");

    // The queue can only fill up behind a stalled output.
    a_ready_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready && in_valid))
        else $error("input ready dropped without an output stall");

endmodule

bind rabin_fingerprint_word_hash rfp_checker u_rfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .fingerprint (rsp.fingerprint)
);
